/* design/dcs_pkg.sv */
// ----------------------------------------------------------------------------
// dcs_pkg: shared types and constants of the DMA channel sequencer
// Item kinds, queue entry and result layouts, register indexes and the
// per-channel address and count masks.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

    // Depth of the queue between the front and the back part.
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    localparam int unsigned CfgIndexW = 3;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] REG_SOURCE_ADDRESS = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_DEST_ADDRESS   = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_UNIT_COUNT     = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_DEST_MODE      = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_SOURCE_MODE    = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_WORD_UNITS     = 3'd5;
    localparam logic [CfgIndexW-1:0] REG_REPEAT_ENABLE  = 3'd6;
    localparam logic [CfgIndexW-1:0] REG_IRQ_ENABLE     = 3'd7;

    // Address step modes.
    localparam logic [1:0] MODE_INC    = 2'd0;
    localparam logic [1:0] MODE_DEC    = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;
    localparam logic [1:0] MODE_RELOAD = 2'd3;

    localparam logic [31:0] BIOS_TOP     = 32'h01FF_FFFF;
    localparam logic [31:0] ROM_BASE     = 32'h0800_0000;
    localparam logic [31:0] ROM_END      = 32'h0E00_0000;
    localparam logic [16:0] MAX_COUNT_CH3 = 17'h1_0000;
    localparam logic [16:0] MAX_COUNT     = 17'h0_4000;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_UNIT  = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [31:0] read_data;
    } queue_entry_t;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

    typedef struct packed {
        logic        channel_active;
        logic        irq_pulse;
        logic        run_done;
        logic        word_write;
        logic        write_valid;
        logic [31:0] write_data;
        logic [27:0] write_addr;
        logic        read_sequential;
        logic        read_valid;
        logic [27:0] read_addr;
    } result_t;

    function automatic logic [31:0] src_mask(input logic [1:0] ch);
        return (ch == 2'd0) ? 32'h07FF_FFFF : 32'h0FFF_FFFF;
    endfunction

    function automatic logic [31:0] dst_mask(input logic [1:0] ch);
        return (ch == 2'd3) ? 32'h0FFF_FFFF : 32'h07FF_FFFF;
    endfunction

    function automatic logic [15:0] cnt_mask(input logic [1:0] ch);
        return (ch == 2'd3) ? 16'hFFFF : 16'h3FFF;
    endfunction

endpackage

`default_nettype wire

/* design/dcs_front.sv */
// ----------------------------------------------------------------------------
// dcs_front: input side of the DMA channel sequencer
// Accepts input words, classifies them as run starts or unit steps and
// queues them for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,
    input  wire logic                 s_tuser,
    output dcs_pkg::queue_head_t      head,
    input  wire logic                 pop
);

    dcs_pkg::queue_entry_t               mem_reg [dcs_pkg::QueueDepth];
    logic [dcs_pkg::QueuePtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [dcs_pkg::QueuePtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [dcs_pkg::QueueCntW-1:0]       count_reg, count_next;
    logic                                push;
    dcs_pkg::queue_entry_t               entry_in;

    assign s_tready = (count_reg != dcs_pkg::QueueCntW'(dcs_pkg::QueueDepth));
    assign push     = s_tvalid && s_tready;

    always_comb begin
        entry_in.kind      = s_tuser ? dcs_pkg::KIND_UNIT : dcs_pkg::KIND_START;
        entry_in.read_data = s_tdata;
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dcs_pkg::QueueCntW'(dcs_pkg::QueueDepth))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

`default_nettype wire

/* design/dcs_back.sv */
// ----------------------------------------------------------------------------
// dcs_back: execution part of the DMA channel sequencer
// Holds the configuration and the channel state, carries out queued items
// one per cycle unless the output stalls, and keeps the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_back #(
    parameter int unsigned CHANNEL = 3
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    input  wire logic [dcs_pkg::CfgIndexW-1:0]      cfg_index,
    input  wire logic [31:0]                        cfg_data,
    input  wire dcs_pkg::queue_head_t               head,
    output logic                                    pop,
    output logic                                    res_valid,
    output dcs_pkg::result_t                        res,
    input  wire logic                               res_ready
);

    localparam logic [1:0] Ch = 2'(CHANNEL);

    // Configuration registers.
    logic [31:0] source_address_reg, dest_address_reg;
    logic [15:0] unit_count_reg;
    logic [1:0]  dest_mode_reg, source_mode_reg;
    logic        word_units_reg, repeat_enable_reg, irq_enable_reg;

    // Channel state.
    logic [31:0] src_ptr_reg, src_ptr_next;
    logic [31:0] dst_ptr_reg, dst_ptr_next;
    logic [16:0] units_left_reg, units_left_next;
    logic [31:0] open_bus_reg, open_bus_next;
    logic        open_half_reg, open_half_next;
    logic        enable_reg, enable_next;
    logic        first_reg, first_next;
    logic        stale_reg, stale_next;

    logic             res_valid_reg;
    dcs_pkg::result_t res_reg, res_next;

    logic [31:0] size;
    logic [31:0] src_base, dst_base, ms, value;
    logic [31:0] src_next_m, dst_m;
    logic [15:0] count_masked;
    logic        rom;

    assign pop       = head.valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    function automatic logic [31:0] align_unit(input logic [31:0] a, input logic word);
        return word ? {a[31:2], 2'b00} : {a[31:1], 1'b0};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_address_reg <= '0;
            dest_address_reg   <= '0;
            unit_count_reg     <= '0;
            dest_mode_reg      <= '0;
            source_mode_reg    <= '0;
            word_units_reg     <= 1'b0;
            repeat_enable_reg  <= 1'b0;
            irq_enable_reg     <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                dcs_pkg::REG_SOURCE_ADDRESS: source_address_reg <= cfg_data;
                dcs_pkg::REG_DEST_ADDRESS:   dest_address_reg   <= cfg_data;
                dcs_pkg::REG_UNIT_COUNT:     unit_count_reg     <= cfg_data[15:0];
                dcs_pkg::REG_DEST_MODE:      dest_mode_reg      <= cfg_data[1:0];
                dcs_pkg::REG_SOURCE_MODE:    source_mode_reg    <= cfg_data[1:0];
                dcs_pkg::REG_WORD_UNITS:     word_units_reg     <= cfg_data[0];
                dcs_pkg::REG_REPEAT_ENABLE:  repeat_enable_reg  <= cfg_data[0];
                dcs_pkg::REG_IRQ_ENABLE:     irq_enable_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        src_ptr_next    = src_ptr_reg;
        dst_ptr_next    = dst_ptr_reg;
        units_left_next = units_left_reg;
        open_bus_next   = open_bus_reg;
        open_half_next  = open_half_reg;
        enable_next     = enable_reg;
        first_next      = first_reg;
        stale_next      = stale_reg;
        res_next        = '0;
        src_next_m      = '0;

        size  = word_units_reg ? 32'd4 : 32'd2;
        ms    = src_ptr_reg & dcs_pkg::src_mask(Ch);
        dst_m = dst_ptr_reg & dcs_pkg::dst_mask(Ch);
        rom   = (source_address_reg >= dcs_pkg::ROM_BASE) &&
                (source_address_reg < dcs_pkg::ROM_END);
        count_masked = unit_count_reg & dcs_pkg::cnt_mask(Ch);

        src_base = stale_reg ? source_address_reg : src_ptr_reg;
        dst_base = (stale_reg || dest_mode_reg == dcs_pkg::MODE_RELOAD) ?
                   dest_address_reg : dst_ptr_reg;

        // Data for a unit: the open-bus latch below the end of the BIOS region,
        // bus data elsewhere.
        if (ms <= dcs_pkg::BIOS_TOP) begin
            if (!word_units_reg) begin
                value = {16'h0000, open_bus_reg[15:0]};
            end else if (open_half_reg) begin
                value = {open_bus_reg[15:0], open_bus_reg[15:0]};
            end else begin
                value = open_bus_reg;
            end
        end else begin
            value = word_units_reg ? head.entry.read_data :
                    {16'h0000, head.entry.read_data[15:0]};
        end

        if (head.entry.kind == dcs_pkg::KIND_START) begin
            stale_next      = 1'b0;
            src_ptr_next    = align_unit(src_base, word_units_reg);
            dst_ptr_next    = align_unit(dst_base, word_units_reg);
            units_left_next = (count_masked != '0) ? {1'b0, count_masked} :
                              ((Ch == 2'd3) ? dcs_pkg::MAX_COUNT_CH3 : dcs_pkg::MAX_COUNT);
            enable_next     = 1'b1;
            first_next      = 1'b1;
            src_next_m      = src_ptr_next & dcs_pkg::src_mask(Ch);
            res_next.read_addr       = src_next_m[27:0];
            res_next.read_valid      = src_next_m > dcs_pkg::BIOS_TOP;
            res_next.read_sequential = 1'b0;
            res_next.channel_active  = 1'b1;
        end else if (!enable_reg || units_left_reg == '0) begin
            res_next.channel_active = enable_reg;
        end else begin
            if (ms > dcs_pkg::BIOS_TOP) begin
                open_bus_next  = value;
                open_half_next = !word_units_reg;
            end
            res_next.write_addr  = dst_m[27:0];
            res_next.write_data  = value;
            res_next.write_valid = !(Ch == 2'd0 && ms >= dcs_pkg::ROM_END);
            res_next.word_write  = word_units_reg;

            case (dest_mode_reg)
                dcs_pkg::MODE_INC, dcs_pkg::MODE_RELOAD: dst_ptr_next = dst_ptr_reg + size;
                dcs_pkg::MODE_DEC:                       dst_ptr_next = dst_ptr_reg - size;
                default:                                 dst_ptr_next = dst_ptr_reg;
            endcase

            if (rom || source_mode_reg == dcs_pkg::MODE_INC) begin
                src_ptr_next = src_ptr_reg + size;
            end else if (source_mode_reg == dcs_pkg::MODE_DEC) begin
                src_ptr_next = src_ptr_reg - size;
            end

            units_left_next = units_left_reg - 1'b1;
            first_next      = 1'b0;

            if (units_left_next == '0) begin
                res_next.run_done  = 1'b1;
                res_next.irq_pulse = irq_enable_reg;
                enable_next        = repeat_enable_reg;
                if (!repeat_enable_reg) begin
                    stale_next = 1'b1;
                end
            end else begin
                src_next_m               = src_ptr_next & dcs_pkg::src_mask(Ch);
                res_next.read_addr       = src_next_m[27:0];
                res_next.read_valid      = src_next_m > dcs_pkg::BIOS_TOP;
                res_next.read_sequential = 1'b1;
            end
            res_next.channel_active = enable_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_ptr_reg    <= '0;
            dst_ptr_reg    <= '0;
            units_left_reg <= '0;
            open_bus_reg   <= '0;
            open_half_reg  <= 1'b0;
            enable_reg     <= 1'b0;
            first_reg      <= 1'b1;
            stale_reg      <= 1'b1;
            res_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                src_ptr_reg    <= src_ptr_next;
                dst_ptr_reg    <= dst_ptr_next;
                units_left_reg <= units_left_next;
                open_bus_reg   <= open_bus_next;
                open_half_reg  <= open_half_next;
                enable_reg     <= enable_next;
                first_reg      <= first_next;
                stale_reg      <= stale_next;
                res_valid_reg  <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> res_valid_reg)
        else $error("consumed item left no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        units_left_reg != '0 |-> enable_reg)
        else $error("units pending on a disabled channel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.irq_pulse) |-> res_reg.run_done)
        else $error("interrupt outside the end of a run");

endmodule

`default_nettype wire

/* design/dma_channel_sequencer.sv */
// ----------------------------------------------------------------------------
// dma_channel_sequencer: one DMA channel of a handheld console
// Top level joining the input queue, the execution part and the ports.
// ----------------------------------------------------------------------------
// How to use this block:
// The channel is programmed through the cfg port, one register per word, and
// only while no item is in flight. Each input word on the s_ channel is either
// a run start (s_tuser = 0) or a unit step (s_tuser = 1) that carries the bus
// data for the read announced by the previous result word. Every input word
// produces exactly one result word on the m_ channel, which names the write
// to perform, the next read to issue, and the end of the run on m_tlast.
// Input words enter a four-entry queue; the execution part takes one word from
// the queue per clock while the output is not stalled, so the channel sustains
// one word per cycle while m_tready stays high. A word accepted on an empty
// block is written into the queue, executed from its head into the output
// register and offered on m_ from that register.
// When the receiver holds m_tready low,
// the output register keeps its word, execution pauses and the queue fills;
// s_tready falls only once all four queue entries are taken.
// Reset clears the queue, the output valid flag, the channel state and all
// configuration registers; the first run start then loads both pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_channel_sequencer #(
    parameter int unsigned CHANNEL = 3
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input channel.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,   // [31:0] read_data
    input  wire logic                           s_tuser,   // [0] cmd
    // Result channel.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [27:0] read_addr, [28] read_valid, [29] read_sequential,
    // [57:30] write_addr, [89:58] write_data, [90] write_valid,
    // [91] word_write, [92] irq_pulse, [93] channel_active, [95:94] zero
    output logic [95:0]                         m_tdata,
    output logic                                m_tlast,   // run_done
    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dcs_pkg::CfgIndexW-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    dcs_pkg::queue_head_t head;
    dcs_pkg::result_t     res;
    logic                 pop;

    // Register writes are always taken at once.
    assign cfg_ready = 1'b1;

    dcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    dcs_back #(
        .CHANNEL (CHANNEL)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {2'b00,
                      res.channel_active,
                      res.irq_pulse,
                      res.word_write,
                      res.write_valid,
                      res.write_data,
                      res.write_addr,
                      res.read_sequential,
                      res.read_valid,
                      res.read_addr};
    assign m_tlast = res.run_done;

endmodule

`default_nettype wire
